### design/tdl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the two-wire display link master
// used by tdl_front, tdl_queue, tdl_back and the top level
package tdl_pkg;

  // kind codes as they arrive on the slave-side tuser
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  // one classified tick as it sits in the queue
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
    logic       line_level;
  } tick_t;

  // one result beat
  typedef struct packed {
    logic       finished;
    logic [7:0] received_byte;
    logic       busy_res;
    logic       data_drive;
    logic       data_pin;
    logic       clock_pin;
  } res_t;

endpackage

### design/tdl_front.sv
`timescale 1ns / 1ps
// front end: takes slave-side beats and classifies the kind field
// into a command; depends on tdl_pkg
module tdl_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tdl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [2:0]                       s_axis_tuser,
  output logic                             push_o,
  output tdl_pkg::tick_t                   tick_o,
  input  logic                             full_i
);
  import tdl_pkg::*;

  cmd_e cmd;

  always_comb begin
    case (s_axis_tuser)
      KIND_START: cmd = CMD_START;
      KIND_STOP:  cmd = CMD_STOP;
      KIND_WRITE: cmd = CMD_WRITE;
      KIND_READ:  cmd = CMD_READ;
      default:    cmd = CMD_NONE; // plain tick and unused codes
    endcase
  end

  assign s_axis_tready     = ~full_i;
  assign push_o            = s_axis_tvalid & ~full_i;
  assign tick_o.cmd        = cmd;
  assign tick_o.data_byte  = s_axis_tdata[7:0];
  assign tick_o.line_level = s_axis_tdata[8];

endmodule

### design/tdl_queue.sv
`timescale 1ns / 1ps
// two-entry queue of classified ticks between front and back
// depends on tdl_pkg
module tdl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tdl_pkg::tick_t tick_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tdl_pkg::tick_t tick_o
);
  import tdl_pkg::*;

  tick_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = |count_q;
  assign tick_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tick_i;
    end
  end

endmodule

### design/tdl_back.sv
`timescale 1ns / 1ps
// back end: pin sequencer, one step per tick, with a result register
// that parts it from the master side; depends on tdl_pkg
module tdl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tdl_pkg::tick_t tick_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output tdl_pkg::res_t  res_o,
  input  logic           res_ready_i
);
  import tdl_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_S_CLKH = 4'd1;
  localparam logic [3:0] PH_S_DATL = 4'd2;
  localparam logic [3:0] PH_S_CLKL = 4'd3;
  localparam logic [3:0] PH_T_CLKH = 4'd4;
  localparam logic [3:0] PH_T_DATH = 4'd5;
  localparam logic [3:0] PH_W_LOW  = 4'd6;
  localparam logic [3:0] PH_W_DATA = 4'd7;
  localparam logic [3:0] PH_W_HIGH = 4'd8;
  localparam logic [3:0] PH_R_LOW  = 4'd9;
  localparam logic [3:0] PH_R_HIGH = 4'd10;
  localparam logic [3:0] PH_A_LOW  = 4'd11;
  localparam logic [3:0] PH_A_WAIT = 4'd12;
  localparam logic [3:0] PH_A_FALL = 4'd13;

  logic [3:0] phase_q, phase_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic       clk_lvl_q, clk_lvl_d;
  logic       dat_lvl_q, dat_lvl_d;
  logic       drive_q, drive_d;
  logic [7:0] rd_res_q, rd_res_d;
  logic       done;
  logic       res_valid_q;
  res_t       res_q, res_d;

  assign pop_o = q_valid_i & (~res_valid_q | res_ready_i);

  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    clk_lvl_d = clk_lvl_q;
    dat_lvl_d = dat_lvl_q;
    drive_d   = drive_q;
    rd_res_d  = rd_res_q;
    done      = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        case (tick_i.cmd)
          CMD_START: begin
            dat_lvl_d = 1'b1;
            drive_d   = 1'b1;
            phase_d   = PH_S_CLKH;
          end
          CMD_STOP: begin
            dat_lvl_d = 1'b0;
            drive_d   = 1'b1;
            phase_d   = PH_T_CLKH;
          end
          CMD_WRITE: begin
            shift_d   = tick_i.data_byte;
            bit_idx_d = 3'd0;
            drive_d   = 1'b1;
            clk_lvl_d = 1'b0;
            phase_d   = PH_W_DATA;
          end
          CMD_READ: begin
            shift_d   = 8'd0;
            bit_idx_d = 3'd0;
            drive_d   = 1'b0;
            dat_lvl_d = 1'b1;
            phase_d   = PH_R_LOW;
          end
          default: ;
        endcase
      end
      PH_S_CLKH: begin
        clk_lvl_d = 1'b1;
        phase_d   = PH_S_DATL;
      end
      PH_S_DATL: begin
        dat_lvl_d = 1'b0;
        phase_d   = PH_S_CLKL;
      end
      PH_S_CLKL: begin
        clk_lvl_d = 1'b0;
        phase_d   = PH_IDLE;
        done      = 1'b1;
      end
      PH_T_CLKH: begin
        clk_lvl_d = 1'b1;
        phase_d   = PH_T_DATH;
      end
      PH_T_DATH: begin
        dat_lvl_d = 1'b1;
        phase_d   = PH_IDLE;
        done      = 1'b1;
      end
      PH_W_LOW: begin
        clk_lvl_d = 1'b0;
        phase_d   = PH_W_DATA;
      end
      PH_W_DATA: begin
        // lsb first
        dat_lvl_d = shift_q[0];
        shift_d   = {1'b0, shift_q[7:1]};
        phase_d   = PH_W_HIGH;
      end
      PH_W_HIGH: begin
        clk_lvl_d = 1'b1;
        bit_idx_d = bit_idx_q + 3'd1;
        phase_d   = (&bit_idx_q) ? PH_A_LOW : PH_W_LOW;
      end
      PH_R_LOW: begin
        clk_lvl_d = 1'b0;
        shift_d   = {1'b0, shift_q[7:1]};
        phase_d   = PH_R_HIGH;
      end
      PH_R_HIGH: begin
        clk_lvl_d = 1'b1;
        shift_d   = {shift_q[7] | tick_i.line_level, shift_q[6:0]};
        bit_idx_d = bit_idx_q + 3'd1;
        if (&bit_idx_q) begin
          rd_res_d = shift_d;
          phase_d  = PH_A_LOW;
        end else begin
          phase_d  = PH_R_LOW;
        end
      end
      PH_A_LOW: begin
        clk_lvl_d = 1'b0;
        drive_d   = 1'b0;
        dat_lvl_d = 1'b1;
        phase_d   = PH_A_WAIT;
      end
      PH_A_WAIT: begin
        // no timeout on the acknowledge
        if (!tick_i.line_level) begin
          clk_lvl_d = 1'b1;
          phase_d   = PH_A_FALL;
        end
      end
      PH_A_FALL: begin
        clk_lvl_d = 1'b0;
        phase_d   = PH_IDLE;
        done      = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    res_d.clock_pin     = clk_lvl_d;
    res_d.data_pin      = dat_lvl_d;
    res_d.data_drive    = drive_d;
    res_d.busy_res      = (phase_d != PH_IDLE);
    res_d.received_byte = rd_res_d;
    res_d.finished      = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_idx_q   <= 3'd0;
      shift_q     <= 8'd0;
      clk_lvl_q   <= 1'b1;
      dat_lvl_q   <= 1'b1;
      drive_q     <= 1'b1;
      rd_res_q    <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        bit_idx_q <= bit_idx_d;
        shift_q   <= shift_d;
        clk_lvl_q <= clk_lvl_d;
        dat_lvl_q <= dat_lvl_d;
        drive_q   <= drive_d;
        rd_res_q  <= rd_res_d;
      end
      if (pop_o) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.finished) |-> !res_q.busy_res)
    else $error("finished beat reports busy");

  a_bit_idx_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_idx_q != 3'd0) |-> (phase_q == PH_W_LOW || phase_q == PH_W_DATA ||
                             phase_q == PH_W_HIGH || phase_q == PH_R_LOW ||
                             phase_q == PH_R_HIGH))
    else $error("bit counter left nonzero outside a byte transfer");

  a_ack_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_A_WAIT || phase_q == PH_A_FALL) |-> !drive_q)
    else $error("data line driven during acknowledge");

  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |-> !pop_o)
    else $error("sequencer stepped while result register stalled");

endmodule

### design/two_wire_display_link_master_core.sv
`timescale 1ns / 1ps
// top level of the two-wire display link master
// instantiates tdl_front, tdl_queue and tdl_back; depends on tdl_pkg
//
// each slave-side beat is one pin step: the sequencer advances one step and
// returns exactly one master-side beat with the pin levels after that step.
// a beat can be taken every clock cycle while the tick queue is not full. an
// accepted tick is written to the two-entry tick queue, and its result beat
// is then registered in the result register; master-side stalls hold ticks
// in the queue behind the result register, and tready drops once it is full.
// a command in tuser is acted on only while no sequence is in progress;
// otherwise it is a plain tick. tlast marks the beat on which a start, stop,
// write or read sequence completes.
module two_wire_display_link_master_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] data_byte, [8] line_level, [15:9] zero
  input  logic [tdl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] clock_pin, [1] data_pin, [2] data_drive, [3] busy_res,
  // [11:4] received_byte, [15:12] zero
  output logic [tdl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // finished
  output logic                                m_axis_tlast
);
  import tdl_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  q_valid;
  tick_t tick_in;
  tick_t tick_q;
  res_t  res;

  tdl_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .tick_o        (tick_in),
    .full_i        (full)
  );

  tdl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tick_i  (tick_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .tick_o  (tick_q)
  );

  tdl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .tick_i      (tick_q),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, res.received_byte, res.busy_res, res.data_drive,
                         res.data_pin, res.clock_pin};
  assign m_axis_tlast = res.finished;

endmodule

### test/tdl_link_checker.sv
`timescale 1ns / 1ps
// scoreboard for the two-wire display link master: watches both stream ports,
// predicts one result beat per accepted tick and compares it field by field
// depends on tdl_pkg
module tdl_link_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [tdl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [2:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [tdl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,
  output int                              error_count_o,
  output int                              pending_count_o
);
  import tdl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_CLK_HI,
    ST_START_DATA_LO,
    ST_START_CLK_LO,
    ST_STOP_CLK_HI,
    ST_STOP_DATA_HI,
    ST_WR_CLK_LO,
    ST_WR_DATA,
    ST_WR_CLK_HI,
    ST_RD_CLK_LO,
    ST_RD_CLK_HI,
    ST_ACK_CLK_LO,
    ST_ACK_WAIT,
    ST_ACK_CLK_FALL
  } link_step_e;

  link_step_e step_q;
  logic [2:0] bit_cnt_q;
  logic [7:0] shreg_q;
  logic       scl_q;
  logic       sda_q;
  logic       sda_oe_q;
  logic [7:0] rx_byte_q;
  res_t       pin_levels;
  res_t       pin_expect_q[$];

  task automatic report_mismatch(input string msg);
    error_count_o++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic reset_link();
    step_q    = ST_IDLE;
    bit_cnt_q = 3'd0;
    shreg_q   = 8'h00;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    sda_oe_q  = 1'b1;
    rx_byte_q = 8'h00;
  endtask

  // one pin step of the bus sequencer
  task automatic step_link(input logic [2:0] kind, input logic [7:0] data_in,
                           input logic line, output res_t pins);
    logic done;
    done = 1'b0;
    case (step_q)
      ST_IDLE: begin
        case (kind)
          KIND_START: begin
            sda_q = 1'b1; sda_oe_q = 1'b1; step_q = ST_START_CLK_HI;
          end
          KIND_STOP: begin
            sda_q = 1'b0; sda_oe_q = 1'b1; step_q = ST_STOP_CLK_HI;
          end
          KIND_WRITE: begin
            shreg_q = data_in; bit_cnt_q = 3'd0;
            sda_oe_q = 1'b1; scl_q = 1'b0; step_q = ST_WR_DATA;
          end
          KIND_READ: begin
            shreg_q = 8'h00; bit_cnt_q = 3'd0;
            sda_oe_q = 1'b0; sda_q = 1'b1; step_q = ST_RD_CLK_LO;
          end
          default: ;
        endcase
      end
      ST_START_CLK_HI:  begin scl_q = 1'b1; step_q = ST_START_DATA_LO; end
      ST_START_DATA_LO: begin sda_q = 1'b0; step_q = ST_START_CLK_LO; end
      ST_START_CLK_LO:  begin scl_q = 1'b0; step_q = ST_IDLE; done = 1'b1; end
      ST_STOP_CLK_HI:   begin scl_q = 1'b1; step_q = ST_STOP_DATA_HI; end
      ST_STOP_DATA_HI:  begin sda_q = 1'b1; step_q = ST_IDLE; done = 1'b1; end
      ST_WR_CLK_LO:     begin scl_q = 1'b0; step_q = ST_WR_DATA; end
      ST_WR_DATA: begin
        // lsb first
        sda_q   = shreg_q[0];
        shreg_q = shreg_q >> 1;
        step_q  = ST_WR_CLK_HI;
      end
      ST_WR_CLK_HI: begin
        scl_q = 1'b1;
        if (bit_cnt_q == 3'd7) begin
          bit_cnt_q = 3'd0; step_q = ST_ACK_CLK_LO;
        end else begin
          bit_cnt_q = bit_cnt_q + 3'd1; step_q = ST_WR_CLK_LO;
        end
      end
      ST_RD_CLK_LO: begin
        scl_q = 1'b0; shreg_q = shreg_q >> 1; step_q = ST_RD_CLK_HI;
      end
      ST_RD_CLK_HI: begin
        scl_q = 1'b1;
        if (line) shreg_q[7] = 1'b1;
        if (bit_cnt_q == 3'd7) begin
          bit_cnt_q = 3'd0; rx_byte_q = shreg_q; step_q = ST_ACK_CLK_LO;
        end else begin
          bit_cnt_q = bit_cnt_q + 3'd1; step_q = ST_RD_CLK_LO;
        end
      end
      ST_ACK_CLK_LO: begin
        scl_q = 1'b0; sda_oe_q = 1'b0; sda_q = 1'b1; step_q = ST_ACK_WAIT;
      end
      // no time limit: stays here until the slave pulls the line low
      ST_ACK_WAIT: begin
        if (!line) begin
          scl_q = 1'b1; step_q = ST_ACK_CLK_FALL;
        end
      end
      ST_ACK_CLK_FALL: begin scl_q = 1'b0; step_q = ST_IDLE; done = 1'b1; end
      default: step_q = ST_IDLE;
    endcase
    pins.clock_pin     = scl_q;
    pins.data_pin      = sda_q;
    pins.data_drive    = sda_oe_q;
    pins.busy_res      = (step_q != ST_IDLE);
    pins.received_byte = rx_byte_q;
    pins.finished      = done;
  endtask

  task automatic check_beat(input res_t want);
    if (m_axis_tdata[0] !== want.clock_pin)
      report_mismatch($sformatf("clock_pin got %b expected %b",
                                m_axis_tdata[0], want.clock_pin));
    if (m_axis_tdata[1] !== want.data_pin)
      report_mismatch($sformatf("data_pin got %b expected %b",
                                m_axis_tdata[1], want.data_pin));
    if (m_axis_tdata[2] !== want.data_drive)
      report_mismatch($sformatf("data_drive got %b expected %b",
                                m_axis_tdata[2], want.data_drive));
    if (m_axis_tdata[3] !== want.busy_res)
      report_mismatch($sformatf("busy_res got %b expected %b",
                                m_axis_tdata[3], want.busy_res));
    if (m_axis_tdata[11:4] !== want.received_byte)
      report_mismatch($sformatf("received_byte got %h expected %h",
                                m_axis_tdata[11:4], want.received_byte));
    if (m_axis_tdata[15:12] !== 4'h0)
      report_mismatch($sformatf("tdata padding got %h expected 0",
                                m_axis_tdata[15:12]));
    if (m_axis_tlast !== want.finished)
      report_mismatch($sformatf("finished got %b expected %b",
                                m_axis_tlast, want.finished));
  endtask

  // result side first: a beat accepted on this edge is always an older one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_link();
      pin_expect_q.delete();
      pending_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pin_expect_q.size() == 0)
          report_mismatch($sformatf("result beat %h with nothing outstanding",
                                    m_axis_tdata));
        else
          check_beat(pin_expect_q.pop_front());
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_link(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8], pin_levels);
        pin_expect_q.push_back(pin_levels);
      end
      pending_count_o = pin_expect_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// top of the two-wire display link master testbench: clock, reset, tick
// stimulus and receiver back-pressure; checking lives in tdl_link_checker
// depends on tdl_pkg, tdl_link_checker and two_wire_display_link_master_core
module tb_top;
  import tdl_pkg::*;

  localparam int ITEM_TARGET  = 1250;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  // kind codes with no command behind them
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data;
  logic [2:0]             s_user;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic                   m_last;
  int                     error_count;
  int                     pending_count;
  int                     items_sent = 0;
  int                     idle_cycles = 0;
  int                     ready_run = 0;
  int                     ready_pick;
  bit                     no_gap = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  two_wire_display_link_master_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  tdl_link_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_valid),
    .s_axis_tready   (s_ready),
    .s_axis_tdata    (s_data),
    .s_axis_tuser    (s_user),
    .m_axis_tvalid   (m_valid),
    .m_axis_tready   (m_ready),
    .m_axis_tdata    (m_data),
    .m_axis_tlast    (m_last),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  // receiver stalls: mostly short, a few long, and long stall-free stretches
  always @(posedge clk_i) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        m_ready <= 1'b1; ready_run <= $urandom_range(0, 19);
      end else if (ready_pick < 85) begin
        m_ready <= 1'b0; ready_run <= $urandom_range(0, 2);
      end else if (ready_pick < 95) begin
        m_ready <= 1'b1; ready_run <= $urandom_range(50, 200);
      end else begin
        m_ready <= 1'b0; ready_run <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gap || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // kind field while a sequence runs: mostly plain ticks, some ignored commands
  function automatic logic [2:0] busy_kind();
    if ($urandom_range(0, 99) < 80) return KIND_TICK;
    return 3'($urandom_range(KIND_TICK, KIND_SPARE_HI));
  endfunction

  function automatic logic line_with_bias(input int high_pct);
    return ($urandom_range(0, 99) < high_pct);
  endfunction

  task automatic send_beat(input logic [2:0] kind, input logic [7:0] data_in,
                           input logic line);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {7'd0, line, data_in};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic idle_ticks(input int count);
    logic [2:0] kind;
    repeat (count) begin
      kind = ($urandom_range(0, 1) != 0) ? KIND_TICK
                                         : 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      send_beat(kind, 8'($urandom), 1'($urandom));
    end
  endtask

  // one complete command; ticks after the command beat are counted to land
  // exactly on the end of the sequence
  task automatic run_sequence(input logic [2:0] cmd, input logic [7:0] data_in,
                              input int high_pct, input int ack_hold);
    int body;
    case (cmd)
      KIND_START: body = 3;
      KIND_STOP:  body = 2;
      KIND_WRITE: body = 24;
      default:    body = 17;
    endcase
    send_beat(cmd, data_in, line_with_bias(high_pct));
    repeat (body) send_beat(busy_kind(), 8'($urandom), line_with_bias(high_pct));
    if (cmd == KIND_WRITE || cmd == KIND_READ) begin
      // slave holds the line high for a while before acknowledging
      repeat (ack_hold) send_beat(busy_kind(), 8'($urandom), 1'b1);
      send_beat(busy_kind(), 8'($urandom), 1'b0);
      send_beat(busy_kind(), 8'($urandom), 1'($urandom));
    end
  endtask

  // random junk, then enough plain low-line ticks to bring the link back to idle
  task automatic scramble();
    repeat ($urandom_range(1, 30))
      send_beat(3'($urandom_range(KIND_TICK, KIND_SPARE_HI)), 8'($urandom),
                1'($urandom));
    repeat (30) send_beat(KIND_TICK, 8'($urandom), 1'b0);
  endtask

  initial begin
    logic [2:0] cmd;
    logic [7:0] data_val;
    int         high_pct;
    int         ack_hold;
    int         roll;

    rst_ni  <= 1'b0;
    s_valid <= 1'b0;
    s_data  <= '0;
    s_user  <= KIND_TICK;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle with plain and unused kinds, then each command once
    send_beat(KIND_TICK, 8'h00, 1'b0);
    send_beat(KIND_SPARE_LO, 8'hFF, 1'b1);
    send_beat(KIND_SPARE_LO + 3'd1, 8'h5A, 1'b0);
    send_beat(KIND_SPARE_HI, 8'hA5, 1'b1);
    run_sequence(KIND_START, 8'h00, 50, 0);
    run_sequence(KIND_STOP, 8'hFF, 50, 0);
    run_sequence(KIND_WRITE, 8'hFF, 50, 0);
    run_sequence(KIND_READ, 8'h00, 100, 4);

    while (items_sent < ITEM_TARGET) begin
      no_gap = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 12) begin
        scramble();
      end else begin
        cmd  = 3'($urandom_range(KIND_START, KIND_READ));
        roll = $urandom_range(0, 99);
        if (roll < 10)      data_val = 8'h00;
        else if (roll < 20) data_val = 8'hFF;
        else                data_val = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10)      high_pct = 0;
        else if (roll < 20) high_pct = 100;
        else                high_pct = 50;
        if ($urandom_range(0, 99) < 80) ack_hold = $urandom_range(0, 3);
        else                            ack_hold = $urandom_range(10, 60);
        idle_ticks($urandom_range(0, 2));
        run_sequence(cmd, data_val, high_pct, ack_hold);
      end
    end

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### two_wire_display_link_master_core.f
design/tdl_pkg.sv
design/tdl_front.sv
design/tdl_queue.sv
design/tdl_back.sv
design/two_wire_display_link_master_core.sv
test/tdl_link_checker.sv
test/tb_top.sv
